// ===== rtl/rvm_pkg.sv =====
// ============================================================================
// rvm_pkg - shared types and constants of the radial vignette mask
// Register indexes, fixed-point constants and the per-cell payload records.
// ============================================================================
package rvm_pkg;

  localparam int MaxDim   = 2048;
  localparam int MinDim   = 8;
  localparam int DimW     = 12;
  localparam int FracW    = 11;
  localparam int PixW     = 11;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;
  localparam int SqSteps  = 23;   // result bits of the square root
  localparam int DivSteps = 16;   // quotient bits of the ramp division
  localparam int R2W      = 25;
  localparam int RestW    = 26;
  localparam int RemW     = 25;
  localparam int RootW    = 23;
  localparam int SpanW    = 22;

  localparam logic [FracW-1:0] QOne      = 11'd1024;
  localparam logic [SpanW-1:0] MinSpan   = 22'd2048;
  localparam logic [7:0]       GreyScale = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_STRENGTH = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_SOFTNESS = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [RestW-1:0] rest;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [SpanW-1:0] rem;
    logic [15:0]      quo;
    logic             full;
  } dv_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d < DimW'(MinDim)) r = DimW'(MinDim);
    if (d > DimW'(MaxDim)) r = DimW'(MaxDim);
    return r;
  endfunction

  function automatic logic [FracW-1:0] clamp_q10(input logic [FracW-1:0] q);
    return (q > QOne) ? QOne : q;
  endfunction

endpackage

// ===== rtl/rvm_sqrt_cell.sv =====
// ============================================================================
// rvm_sqrt_cell - one step of the digit-by-digit square root
// Brings down two radicand bits and decides one root bit.
// ============================================================================
module rvm_sqrt_cell import rvm_pkg::*; (
  input  logic clk,
  input  logic en,
  input  sq_t  d_in,
  output sq_t  d_out
);

  logic [RemW+1:0] cur;
  logic [RemW+1:0] trial;
  sq_t             res_nxt;
  sq_t             res_r;

  always_comb begin
    cur   = {d_in.rem, d_in.rest[RestW-1 -: 2]};
    trial = (RemW+2)'({d_in.root, 2'b01});
    res_nxt.rest = {d_in.rest[RestW-3:0], 2'b00};
    if (cur >= trial) begin
      res_nxt.rem  = RemW'(cur - trial);
      res_nxt.root = {d_in.root[RootW-2:0], 1'b1};
    end else begin
      res_nxt.rem  = cur[RemW-1:0];
      res_nxt.root = {d_in.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign d_out = res_r;

endmodule

// ===== rtl/rvm_div_cell.sv =====
// ============================================================================
// rvm_div_cell - one step of the restoring ramp division
// Decides one quotient bit of (distance past the inner edge) / span.
// ============================================================================
module rvm_div_cell import rvm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SpanW-1:0] span,
  input  dv_t              d_in,
  output dv_t              d_out
);

  logic [SpanW:0] cur;
  dv_t            res_nxt;
  dv_t            res_r;

  always_comb begin
    cur          = {d_in.rem, 1'b0};
    res_nxt.full = d_in.full;
    if (cur >= {1'b0, span}) begin
      res_nxt.rem = SpanW'(cur - {1'b0, span});
      res_nxt.quo = {d_in.quo[14:0], 1'b1};
    end else begin
      res_nxt.rem = cur[SpanW-1:0];
      res_nxt.quo = {d_in.quo[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign d_out = res_r;

endmodule

// ===== rtl/radial_vignette_mask_core.sv =====
// ============================================================================
// radial_vignette_mask_core - radial vignette grey level per pixel
// Pixel coordinate in, smoothstep-shaped vignette grey level out.
// ============================================================================
//
//   channel  | ports                             | direction
//   ---------+-----------------------------------+----------
//   input    | in_valid, in_stall, in_pixel_x/y  | in
//   result   | out_valid, out_stall, out_grey_*  | out
//   config   | cfg_we, cfg_idx, cfg_wdata        | in
//
// One pixel is taken per clock while in_stall is low. The chain has 45
// stages: a front stage, 23 square-root cells, a ramp set-up stage, 16
// division cells, three smoothstep stages and the output register.
// Reset is synchronous and active low; it empties the chain and loads the
// register defaults. Every stage holds its own valid bit, so a stall on the
// result side only backs up stages that are occupied: bubbles are squeezed
// out and new pixels keep flowing while a finished result waits.
module radial_vignette_mask_core import rvm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PixW-1:0]     in_pixel_x,
  input  logic [PixW-1:0]     in_pixel_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_grey_level,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // Stage positions along the chain.
  localparam int StFront = 0;
  localparam int StPre   = StFront + SqSteps + 1;
  localparam int StA     = StPre + DivSteps + 1;
  localparam int StB     = StA + 1;
  localparam int StC     = StB + 1;
  localparam int StOut   = StC + 1;
  localparam int NSt     = StOut + 1;

  // Configuration registers.
  logic [DimW-1:0]  width_r, height_r;
  logic [FracW-1:0] strength_r, radius_r, softness_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DimW'(320);
      height_r   <= DimW'(240);
      strength_r <= FracW'(512);
      radius_r   <= FracW'(512);
      softness_r <= FracW'(512);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:    width_r    <= cfg_wdata;
        REG_HEIGHT:   height_r   <= cfg_wdata;
        REG_STRENGTH: strength_r <= cfg_wdata[FracW-1:0];
        REG_RADIUS:   radius_r   <= cfg_wdata[FracW-1:0];
        REG_SOFTNESS: softness_r <= cfg_wdata[FracW-1:0];
        default: ;
      endcase
    end
  end

  // Derived settings. They are registered from the configuration registers
  // and used by the ramp set-up, division and smoothstep stages.
  logic [DimW-1:0]  w_c, h_c, m_c;
  logic [SpanW-1:0] inner_r, span_r, inner_nxt, span_nxt;
  logic [FracW-1:0] str_r;

  always_comb begin
    w_c       = clamp_dim(width_r);
    h_c       = clamp_dim(height_r);
    m_c       = (w_c < h_c) ? w_c : h_c;
    inner_nxt = SpanW'(clamp_q10(radius_r) * m_c);
    span_nxt  = SpanW'(clamp_q10(softness_r) * m_c);
    if (span_nxt < MinSpan) span_nxt = MinSpan;
  end

  always_ff @(posedge clk) begin
    inner_r <= inner_nxt;
    span_r  <= span_nxt;
    str_r   <= clamp_q10(strength_r);
  end

  // Flow control: stage k loads when stage k-1 moves on.
  logic [NSt-1:0] v_r, v_nxt, mv, take, ld;

  always_comb begin
    for (int k = NSt - 1; k >= 0; k--) begin
      if (k == NSt - 1) mv[k] = v_r[k] & ~out_stall;
      else              mv[k] = v_r[k] & take[k+1];
      take[k] = ~v_r[k] | mv[k];
    end
    ld[0] = in_valid & take[0];
    for (int k = 1; k < NSt; k++) ld[k] = mv[k-1];
    v_nxt = ld | (v_r & ~mv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign in_stall  = ~take[StFront];
  assign out_valid = v_r[StOut];

  // Front stage: doubled offsets from the centre and the squared distance.
  logic [DimW-1:0] dx, dy, x2, y2, wm1, hm1;
  logic [R2W-1:0]  r2;
  sq_t             sq_q [0:SqSteps];
  sq_t             front_r;

  always_comb begin
    x2  = {in_pixel_x, 1'b0};
    y2  = {in_pixel_y, 1'b0};
    wm1 = w_c - 1'b1;
    hm1 = h_c - 1'b1;
    dx  = (x2 >= wm1) ? x2 - wm1 : wm1 - x2;
    dy  = (y2 >= hm1) ? y2 - hm1 : hm1 - y2;
    r2  = R2W'(dx * dx) + R2W'(dy * dy);
  end

  always_ff @(posedge clk) begin
    if (ld[StFront]) begin
      front_r.rest <= {1'b0, r2};
      front_r.rem  <= '0;
      front_r.root <= '0;
    end
  end

  assign sq_q[0] = front_r;

  // Square root of r2 * 2^20, one root bit per cell.
  for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
    rvm_sqrt_cell u_cell (
      .clk   (clk),
      .en    (ld[StFront + 1 + j]),
      .d_in  (sq_q[j]),
      .d_out (sq_q[j+1])
    );
  end

  // Ramp set-up: distance past the inner edge, with saturation at the far
  // edge of the ramp and zero inside the undarkened disc.
  logic [RootW-1:0] radius_px, diff;
  dv_t              pre_nxt, pre_r;
  dv_t              dv_q [0:DivSteps];

  always_comb begin
    radius_px   = sq_q[SqSteps].root;
    diff        = radius_px - RootW'(inner_r);
    pre_nxt.quo  = '0;
    pre_nxt.full = 1'b0;
    pre_nxt.rem  = '0;
    if (radius_px > RootW'(inner_r)) begin
      if (diff >= RootW'(span_r)) pre_nxt.full = 1'b1;
      else                        pre_nxt.rem  = diff[SpanW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[StPre]) pre_r <= pre_nxt;
  end

  assign dv_q[0] = pre_r;

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    rvm_div_cell u_cell (
      .clk   (clk),
      .en    (ld[StPre + 1 + j]),
      .span  (span_r),
      .d_in  (dv_q[j]),
      .d_out (dv_q[j+1])
    );
  end

  // Smoothstep: t^2, then t^2 * (3 - 2t), then strength scaling.
  logic [31:0] tsq_r;
  logic [17:0] coef_r;
  logic        full_a_r, full_b_r;
  logic [49:0] prod_r;
  logic [16:0] f_r, s_c, f_c;
  logic [27:0] sf_c;
  logic [7:0]  grey_r;
  logic [24:0] grey_c;
  logic [15:0] t_q;

  assign t_q = dv_q[DivSteps].quo;

  always_ff @(posedge clk) begin
    if (ld[StA]) begin
      tsq_r    <= t_q * t_q;
      coef_r   <= 18'd196608 - {1'b0, t_q, 1'b0};
      full_a_r <= dv_q[DivSteps].full;
    end
    if (ld[StB]) begin
      prod_r   <= tsq_r * coef_r;
      full_b_r <= full_a_r;
    end
  end

  always_comb begin
    if (full_b_r) s_c = 17'd65536;
    else          s_c = 17'((prod_r + 50'(33'h080000000)) >> 32);
    sf_c = (str_r * s_c) + 28'd512;
    f_c  = (sf_c[27:10] > 18'd65536) ? 17'd65536 : sf_c[26:10];
  end

  always_ff @(posedge clk) begin
    if (ld[StC]) f_r <= f_c;
  end

  // Round-half-up conversion of (1 - f) to an 8-bit grey level.
  assign grey_c = (GreyScale * (17'd65536 - f_r)) + 25'd32768;

  always_ff @(posedge clk) begin
    if (ld[StOut]) grey_r <= grey_c[23:16];
  end

  assign out_grey_level = grey_r;

endmodule

// ===== rtl/rvm_checker.sv =====
// ============================================================================
// rvm_checker - port-level checks of the vignette mask core
// Watches reset, result hold and back-pressure behaviour.
// ============================================================================
module rvm_checker import rvm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_grey_level
);

  // A synchronous reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_grey_level))
    else $error("stalled result changed");

  // The input side can only be held off when a result waits unaccepted.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the chain");

endmodule

bind radial_vignette_mask_core rvm_checker u_rvm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_grey_level (out_grey_level)
);
